// ===== sv/vtc_pkg.sv =====
// ============================================================================
// vtc_pkg: shared types and constants for the virtual tick clock
// Run states, command codes, error codes, sequencer states and register map.
// ============================================================================
package vtc_pkg;

    localparam int unsigned STEP_W    = 32;
    localparam int unsigned TIME_W    = 63;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 32'd1000000;

    typedef enum logic [2:0] {
        RUN_IDLE      = 3'd0,
        RUN_RUNNING   = 3'd1,
        RUN_PAUSED    = 3'd2,
        RUN_STOPPED   = 3'd3,
        RUN_TIMED_OUT = 3'd4
    } t_run_state;

    typedef enum logic [2:0] {
        MODE_RESET   = 3'd0,
        MODE_START   = 3'd1,
        MODE_PAUSE   = 3'd2,
        MODE_RESUME  = 3'd3,
        MODE_STOP    = 3'd4,
        MODE_ADVANCE = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ERR_OK              = 3'd0,
        ERR_BAD_TICK_COUNT  = 3'd1,
        ERR_BAD_TIMEOUT     = 3'd2,
        ERR_ALREADY_STARTED = 3'd3,
        ERR_NOT_RUNNING     = 3'd4,
        ERR_NOT_PAUSED      = 3'd5,
        ERR_ALREADY_STOPPED = 3'd6,
        ERR_TIMEOUT_REACHED = 3'd7
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_NS        = 2'd0,
        CFG_TIMEOUT_ENABLE = 2'd1,
        CFG_TIMEOUT_NS     = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        SEQ_IDLE    = 1'b0,
        SEQ_ADVANCE = 1'b1
    } t_seq_state;

    // control from the sequencer to the tick unit
    typedef struct packed {
        logic clear;
        logic tick;
    } t_tick_ctrl;

endpackage

// ===== sv/virtual_tick_clock_with_timeout.sv =====
// Reset, start, pause, resume, stop, unknown and rejected commands give
//   their result in the cycle after the beat is accepted.
// Advance by N ticks gives its result once the N ticks are done
//   (sooner if the timeout is reached), one tick per cycle through the shared
//   tick unit; one item is in work at a time.
// Reset (i_rst_n low, synchronous): clock idle, counters and armed timeout
//   cleared, configuration back to step 1000000 ns, timeout disabled, zero.
// ============================================================================
// virtual_tick_clock_with_timeout: logical clock controller with timeout
// Decodes one command per input beat, sequences advance tick by tick and
// returns one status beat per command.
// ============================================================================
module virtual_tick_clock_with_timeout #(
    parameter int unsigned TICK_COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vtc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vtc_pkg::TIME_W-1:0]      i_cfg_data,
    // command channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_mode,
    input  logic [TICK_COUNT_WIDTH-1:0]     i_tick_count,
    // status channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_error_code,
    output logic [2:0]                      o_clock_state,
    output logic [vtc_pkg::TICK_W-1:0]      o_tick_total,
    output logic [vtc_pkg::TIME_W-1:0]      o_elapsed_ns,
    output logic                            o_timeout_armed
);
    import vtc_pkg::*;

    // configuration registers
    logic [STEP_W-1:0] r_step_ns;
    logic              r_timeout_en;
    logic [TIME_W-1:0] r_timeout_ns;

    // clock state
    t_run_state        r_run_state, n_run_state;
    logic              r_armed, n_armed;
    logic [TIME_W-1:0] r_armed_timeout, n_armed_timeout;

    // sequencer
    t_seq_state                  r_seq, n_seq;
    logic [TICK_COUNT_WIDTH-1:0] r_remain, n_remain;
    logic                        r_out_valid, n_out_valid;
    t_err                        r_err, n_err;

    logic       w_in_fire;
    logic       w_done;
    logic       w_hit;
    t_tick_ctrl w_ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_seq == SEQ_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire   = i_in_valid && o_in_ready;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ns    <= STEP_RESET;
            r_timeout_en <= 1'b0;
            r_timeout_ns <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_NS:        r_step_ns    <= i_cfg_data[STEP_W-1:0];
                CFG_TIMEOUT_ENABLE: r_timeout_en <= i_cfg_data[0];
                CFG_TIMEOUT_NS:     r_timeout_ns <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // advance finishes on timeout or on its last tick
    assign w_done = (r_seq == SEQ_ADVANCE) &&
                    (w_hit || (r_remain == {{(TICK_COUNT_WIDTH-1){1'b0}}, 1'b1}));

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SEQ_IDLE: begin
                if (w_in_fire && (t_mode'(i_mode) == MODE_ADVANCE) &&
                    (i_tick_count != '0) && (r_run_state == RUN_RUNNING)) begin
                    n_seq = SEQ_ADVANCE;
                end
            end
            SEQ_ADVANCE: begin
                if (w_done) begin
                    n_seq = SEQ_IDLE;
                end
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    // command decode and datapath control
    always_comb begin
        n_run_state     = r_run_state;
        n_armed         = r_armed;
        n_armed_timeout = r_armed_timeout;
        n_remain        = r_remain;
        n_err           = r_err;
        n_out_valid     = r_out_valid && !i_out_ready;
        w_ctrl          = '{clear: 1'b0, tick: 1'b0};

        if (w_in_fire) begin
            n_out_valid = 1'b1;
            n_err       = ERR_OK;
            unique case (t_mode'(i_mode))
                MODE_RESET: begin
                    n_run_state     = RUN_IDLE;
                    n_armed         = 1'b0;
                    n_armed_timeout = '0;
                    w_ctrl.clear    = 1'b1;
                end
                MODE_START: begin
                    if (r_run_state != RUN_IDLE) begin
                        n_err = ERR_ALREADY_STARTED;
                    end else if (r_timeout_en && (r_timeout_ns == '0)) begin
                        n_err = ERR_BAD_TIMEOUT;
                    end else begin
                        n_armed         = r_timeout_en;
                        n_armed_timeout = r_timeout_ns;
                        n_run_state     = RUN_RUNNING;
                    end
                end
                MODE_PAUSE: begin
                    if (r_run_state != RUN_RUNNING) begin
                        n_err = ERR_NOT_RUNNING;
                    end else begin
                        n_run_state = RUN_PAUSED;
                    end
                end
                MODE_RESUME: begin
                    if (r_run_state != RUN_PAUSED) begin
                        n_err = ERR_NOT_PAUSED;
                    end else begin
                        n_run_state = RUN_RUNNING;
                    end
                end
                MODE_STOP: begin
                    if (r_run_state == RUN_STOPPED) begin
                        n_err = ERR_ALREADY_STOPPED;
                    end else if (r_run_state == RUN_IDLE) begin
                        n_err = ERR_NOT_RUNNING;
                    end else begin
                        n_run_state = RUN_STOPPED;
                    end
                end
                MODE_ADVANCE: begin
                    if (i_tick_count == '0) begin
                        n_err = ERR_BAD_TICK_COUNT;
                    end else if (r_run_state != RUN_RUNNING) begin
                        n_err = ERR_NOT_RUNNING;
                    end else begin
                        // hold the result until the ticks are done
                        n_out_valid = 1'b0;
                        n_remain    = i_tick_count;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_seq == SEQ_ADVANCE) begin
            // take one tick through the shared unit
            w_ctrl.tick = 1'b1;
            n_remain    = r_remain - {{(TICK_COUNT_WIDTH-1){1'b0}}, 1'b1};
            if (w_hit) begin
                n_run_state = RUN_TIMED_OUT;
                n_err       = ERR_TIMEOUT_REACHED;
            end
            if (w_done) begin
                n_out_valid = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq           <= SEQ_IDLE;
            r_run_state     <= RUN_IDLE;
            r_armed         <= 1'b0;
            r_armed_timeout <= '0;
            r_out_valid     <= 1'b0;
            r_err           <= ERR_OK;
        end else begin
            r_seq           <= n_seq;
            r_run_state     <= n_run_state;
            r_armed         <= n_armed;
            r_armed_timeout <= n_armed_timeout;
            r_out_valid     <= n_out_valid;
            r_err           <= n_err;
        end
    end

    // remaining tick count
    always_ff @(posedge i_clk) begin
        r_remain <= n_remain;
    end

    vtc_tick_unit u_tick (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_step_ns       (r_step_ns),
        .i_armed         (r_armed),
        .i_armed_timeout (r_armed_timeout),
        .o_tick_total    (o_tick_total),
        .o_elapsed_ns    (o_elapsed_ns),
        .o_hit           (w_hit)
    );

    // status beat: state registers hold while the beat waits
    assign o_out_valid     = r_out_valid;
    assign o_error_code    = r_err;
    assign o_clock_state   = r_run_state;
    assign o_timeout_armed = r_armed;

endmodule

// ===== sv/vtc_tick_unit.sv =====
// ============================================================================
// vtc_tick_unit: shared tick step unit
// Holds tick counter and elapsed time; one saturating tick per enabled cycle
// and the timeout compare on the stepped time.
// ============================================================================
module vtc_tick_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vtc_pkg::t_tick_ctrl          i_ctrl,
    input  logic [vtc_pkg::STEP_W-1:0]   i_step_ns,
    input  logic                         i_armed,
    input  logic [vtc_pkg::TIME_W-1:0]   i_armed_timeout,
    output logic [vtc_pkg::TICK_W-1:0]   o_tick_total,
    output logic [vtc_pkg::TIME_W-1:0]   o_elapsed_ns,
    output logic                         o_hit
);
    import vtc_pkg::*;

    logic [TICK_W-1:0] r_tick;
    logic [TIME_W-1:0] r_elapsed;
    logic [TICK_W-1:0] n_tick;
    logic [TIME_W-1:0] n_elapsed;
    logic [TIME_W:0]   w_sum;

    // step the counters, saturating at all ones
    always_comb begin
        w_sum     = {1'b0, r_elapsed} + {{(TIME_W+1-STEP_W){1'b0}}, i_step_ns};
        n_elapsed = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];
        n_tick    = (&r_tick) ? r_tick : r_tick + {{(TICK_W-1){1'b0}}, 1'b1};
    end

    // timeout reached on this tick
    assign o_hit = i_armed && (n_elapsed >= i_armed_timeout);

    // hold or advance the counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_tick    <= '0;
            r_elapsed <= '0;
        end else if (i_ctrl.tick) begin
            r_tick    <= n_tick;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_tick_total = r_tick;
    assign o_elapsed_ns = r_elapsed;

endmodule
